>>> rtl/stip_pkg.sv
package stip_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 16;
    localparam int CH_W            = 8;
    localparam int RADIX_W         = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = RADIX_W'(0);
    localparam logic [RADIX_W-1:0] RADIX_OCT   = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_HEX   = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

    // Work handed from the front end to the accumulator.
    typedef enum logic {
        OP_DIGIT = 1'b0,
        OP_EMIT  = 1'b1
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic               clr;    // first op of a new string: clear accumulator
        logic               neg;
        logic [RADIX_W-1:0] radix;
        logic [RADIX_W-1:0] digit;
    } t_op_ctl;

endpackage

>>> rtl/stip_if.sv
interface stip_char_if import stip_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface stip_result_if import stip_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   converted;
    logic                   overflow;

    modport source (output valid, output value, output end_offset, output converted,
                    output overflow, input ready);
    modport sink   (input valid, input value, input end_offset, input converted,
                    input overflow, output ready);
endinterface

>>> rtl/stip_front.sv
module stip_front import stip_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [RADIX_W-1:0]     i_cfg_wdata,
    input  logic                   i_accept,
    input  logic [CH_W-1:0]        i_ch,
    input  logic                   i_start_req,
    output logic                   o_push,
    output t_op_ctl                o_ctl,
    output logic [OFFSET_BITS-1:0] o_end
);

    localparam logic [CH_W-1:0] CH_TAB   = CH_W'(9);
    localparam logic [CH_W-1:0] CH_CR    = CH_W'(13);
    localparam logic [CH_W-1:0] CH_SPACE = CH_W'(32);
    localparam logic [CH_W-1:0] CH_PLUS  = CH_W'(43);
    localparam logic [CH_W-1:0] CH_MINUS = CH_W'(45);
    localparam logic [CH_W-1:0] CH_ZERO  = CH_W'(48);
    localparam logic [CH_W-1:0] CH_NINE  = CH_W'(57);
    localparam logic [CH_W-1:0] CH_UA    = CH_W'(65);
    localparam logic [CH_W-1:0] CH_UX    = CH_W'(88);
    localparam logic [CH_W-1:0] CH_UZ    = CH_W'(90);
    localparam logic [CH_W-1:0] CH_LA    = CH_W'(97);
    localparam logic [CH_W-1:0] CH_LX    = CH_W'(120);
    localparam logic [CH_W-1:0] CH_LZ    = CH_W'(122);
    localparam logic [RADIX_W-1:0] NOT_DIGIT = '1;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SPACE  = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_PREFIX = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] t;
        begin
            t = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                t = c - CH_ZERO;
            end else if (c >= CH_LA && c <= CH_LZ) begin
                t = c - CH_LA + CH_W'(10);
            end else if (c >= CH_UA && c <= CH_UZ) begin
                t = c - CH_UA + CH_W'(10);
            end else begin
                t = CH_W'(NOT_DIGIT);
            end
            digit_of = t[RADIX_W-1:0];
        end
    endfunction

    logic [RADIX_W-1:0]     r_radix, n_radix;
    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [RADIX_W-1:0]     r_ar, n_ar;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_clr_pend, n_clr_pend;

    t_phase                 ph;
    logic [OFFSET_BITS-1:0] cur;
    logic [RADIX_W-1:0]     dig;
    logic                   is_space;
    logic                   subj;
    logic                   dend;
    logic                   push;
    logic                   clr;

    assign n_radix = i_cfg_wen ? i_cfg_wdata : r_radix;

    always_comb begin
        ph       = i_start_req ? PH_SPACE : r_phase;
        cur      = i_start_req ? '0 : r_pos;
        clr      = i_start_req | r_clr_pend;
        dig      = digit_of(i_ch);
        is_space = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);

        n_phase  = ph;
        n_neg    = i_start_req ? 1'b0 : r_neg;
        n_ar     = i_start_req ? '0 : r_ar;
        n_pos    = (&cur) ? cur : cur + 1'b1;
        subj     = 1'b0;
        dend     = 1'b0;
        push     = 1'b0;
        o_ctl.kind = OP_DIGIT;
        o_end    = cur;

        case (ph)
            PH_SPACE: begin
                if (is_space) begin
                    n_phase = PH_SPACE;
                end else if (i_ch == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (i_ch == CH_PLUS) begin
                    n_phase = PH_SIGNED;
                end else begin
                    subj = 1'b1;
                end
            end
            PH_SIGNED: subj = 1'b1;
            PH_ZERO: begin
                if (i_ch == CH_LX || i_ch == CH_UX) begin
                    n_ar    = RADIX_HEX;
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = PH_DIGITS;
                    dend    = 1'b1;
                end
            end
            PH_PREFIX: begin
                push = 1'b1;
                if (dig < RADIX_HEX) begin
                    n_phase = PH_DIGITS;
                end else begin
                    // "0x" with no hex digit: the number is the lone '0'
                    o_ctl.kind = OP_EMIT;
                    o_end      = (cur != '0) ? cur - 1'b1 : '0;
                    n_phase    = PH_IDLE;
                end
            end
            PH_DIGITS: dend = 1'b1;
            default: n_phase = PH_IDLE;
        endcase

        if (subj) begin
            if (i_ch == CH_ZERO && (r_radix == RADIX_AUTO || r_radix == RADIX_HEX)) begin
                n_ar    = (r_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                push    = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                if (r_radix == RADIX_AUTO) begin
                    n_ar = RADIX_DEC;
                end else if (r_radix >= RADIX_MIN && r_radix <= RADIX_MAX) begin
                    n_ar = r_radix;
                end else begin
                    n_ar = '0;
                end
                n_phase = PH_DIGITS;
                dend    = 1'b1;
            end
        end

        if (dend) begin
            push = 1'b1;
            if (dig >= n_ar) begin
                o_ctl.kind = OP_EMIT;
                n_phase    = PH_IDLE;
            end
        end

        o_ctl.clr   = clr;
        o_ctl.neg   = n_neg;
        o_ctl.radix = n_ar;
        o_ctl.digit = dig;
        n_clr_pend  = push ? 1'b0 : clr;
        o_push      = i_accept & push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_phase    <= PH_IDLE;
            r_neg      <= 1'b0;
            r_ar       <= '0;
            r_pos      <= '0;
            r_clr_pend <= 1'b0;
        end else begin
            r_radix <= n_radix;
            if (i_accept) begin
                r_phase    <= n_phase;
                r_neg      <= n_neg;
                r_ar       <= n_ar;
                r_pos      <= n_pos;
                r_clr_pend <= n_clr_pend;
            end
        end
    end

endmodule

>>> rtl/stip_queue.sv
module stip_queue import stip_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> rtl/stip_back.sv
module stip_back import stip_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_op_ctl                i_ctl,
    input  logic [OFFSET_BITS-1:0] i_end,
    output logic                   o_pop,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [VALUE_BITS-1:0]  o_value,
    output logic [OFFSET_BITS-1:0] o_end_offset,
    output logic                   o_converted,
    output logic                   o_overflow
);

    localparam int SW = VALUE_BITS + RADIX_W + 1;
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_seen, r_ovf;
    logic                  r_out_valid;

    logic [VALUE_BITS-1:0]         acc_e;
    logic                          seen_e, ovf_e;
    logic [VALUE_BITS+RADIX_W-1:0] prod;
    logic [SW-1:0]                 sum;
    logic [SW-1:0]                 lim;
    logic                          big;

    always_comb begin
        acc_e  = i_ctl.clr ? '0 : r_acc;
        seen_e = i_ctl.clr ? 1'b0 : r_seen;
        ovf_e  = i_ctl.clr ? 1'b0 : r_ovf;
        prod   = acc_e * i_ctl.radix;
        sum    = {1'b0, prod} + SW'(i_ctl.digit);
        // magnitude limit: 2^(N-1) for a negative number, 2^(N-1)-1 otherwise
        lim    = (SW'(1) << (VALUE_BITS - 1)) - SW'(!i_ctl.neg);
        big    = sum > lim;
    end

    assign o_pop       = i_valid & (i_ctl.kind == OP_DIGIT || !r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_ctl.kind)
                OP_DIGIT: begin
                    r_seen <= 1'b1;
                    if (ovf_e || big) begin
                        r_ovf <= 1'b1;
                        r_acc <= acc_e;
                    end else begin
                        r_ovf <= 1'b0;
                        r_acc <= sum[VALUE_BITS-1:0];
                    end
                end
                OP_EMIT: begin
                    r_seen <= seen_e;
                    r_ovf  <= ovf_e;
                    r_acc  <= acc_e;
                    if (!seen_e) begin
                        o_value <= '0;
                    end else if (ovf_e) begin
                        o_value <= i_ctl.neg ? VMIN : VMAX;
                    end else begin
                        o_value <= i_ctl.neg ? (~acc_e + 1'b1) : acc_e;
                    end
                    o_end_offset <= seen_e ? i_end : '0;
                    o_converted  <= seen_e;
                    o_overflow   <= seen_e & ovf_e;
                end
                default: r_acc <= acc_e;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_ctl.kind == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/string_to_integer_parser.sv
// strtol-style parser, one character word per cycle. A word with start_req
// set opens a new string at offset 0; leading whitespace and one sign are
// skipped, radix 0 detects octal/decimal/hex and radix 0 or 16 takes a "0x"
// prefix. The first non-digit closes the string and yields one result word
// (value, end offset, converted, overflow); words after it are ignored until
// the next start. Overflow saturates the value to the signed min or max.
// Rate: one character per clock when not stalled, no bubbles between strings.
// A result is offered from the clock edge after the one that accepts its
// terminating character: the front end classifies the word as it is taken
// and queues it, and the accumulator does its multiply-add-compare on the
// next edge. It comes later only while an earlier result is still held
// unaccepted. That accumulator loop, one radix multiply and one compare per
// cycle, sets the clock. A 2-word queue sits between the front end and the
// accumulator, and the result register lets digits keep flowing while a
// result waits.
// The radix register is written through i_cfg_wen/i_cfg_wdata (reset 10)
// and must only change while no string is in flight.
module string_to_integer_parser import stip_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [RADIX_W-1:0] i_cfg_wdata,
    stip_char_if.sink          i_in,
    stip_result_if.source      o_out
);

    localparam int QW = $bits(t_op_ctl) + OFFSET_BITS;

    // front end -> queue
    logic                   fe_push;
    t_op_ctl                fe_ctl;
    logic [OFFSET_BITS-1:0] fe_end;
    logic                   q_full;
    logic                   accept;

    // queue -> accumulator
    logic                   q_valid;
    logic [QW-1:0]          q_data;
    t_op_ctl                be_ctl;
    logic [OFFSET_BITS-1:0] be_end;
    logic                   be_pop;

    // the front end keeps taking characters as long as the queue has room
    assign i_in.ready = ~q_full;
    assign accept     = i_in.valid & ~q_full;

    stip_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_ch        (i_in.ch),
        .i_start_req (i_in.start_req),
        .o_push      (fe_push),
        .o_ctl       (fe_ctl),
        .o_end       (fe_end)
    );

    stip_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_ctl, fe_end}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (be_pop)
    );

    assign be_ctl = t_op_ctl'(q_data[QW-1:OFFSET_BITS]);
    assign be_end = q_data[OFFSET_BITS-1:0];

    // accumulator and result register
    stip_back #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_ctl        (be_ctl),
        .i_end        (be_end),
        .o_pop        (be_pop),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_value      (o_out.value),
        .o_end_offset (o_out.end_offset),
        .o_converted  (o_out.converted),
        .o_overflow   (o_out.overflow)
    );

endmodule

>>> rtl/stip_checker.sv
module stip_checker import stip_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   i_ready,
    input logic [VALUE_BITS-1:0]  i_value,
    input logic [OFFSET_BITS-1:0] i_end_offset,
    input logic                   i_converted,
    input logic                   i_overflow
);

    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_value) && $stable(i_end_offset))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_converted |-> i_value == '0 && i_end_offset == '0 && !i_overflow)
        else $error("unconverted result not zero");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_overflow |-> i_converted && (i_value == VMIN || i_value == VMAX))
        else $error("overflow result not saturated");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_converted |-> i_end_offset != '0)
        else $error("converted result with zero end offset");

endmodule

bind string_to_integer_parser stip_checker #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
) u_stip_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_value      (o_out.value),
    .i_end_offset (o_out.end_offset),
    .i_converted  (o_out.converted),
    .i_overflow   (o_out.overflow)
);

>>> dv/string_to_integer_parser_test.sv
module string_to_integer_parser_test import stip_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB            = VALUE_BITS_DEF;
    localparam int OB            = OFFSET_BITS_DEF;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int IDLE_PCT      = 36;       // chance of a gap, per word, either side
    localparam int SETTLE_CYCLES = 8;        // queue plus result register, with margin
    localparam int HOLD_AT       = 12;       // result count that starts the long output stall
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_SHOWN     = 10;
    localparam int FIRST_BUDGET  = 160;      // words in the first random phase (carries the stall)
    localparam int PHASE_BUDGET  = 36;       // words in each later random phase
    localparam int RAND_PHASES   = 10;
    localparam int TIMEOUT_NS    = 1_000_000;
    localparam int NO_DIGIT      = 99;

    localparam logic [63:0] VMAX = (64'd1 << (VB - 1)) - 64'd1;

    // characters the parser cares about
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef enum logic [2:0] {
        PS_IDLE, PS_SPACE, PS_SIGNED, PS_ZERO, PS_PREFIX, PS_DIGITS
    } t_parse_phase;

    typedef enum logic [1:0] {
        DG_NONE, DG_SOME, DG_OVF
    } t_digit_state;

    typedef struct packed {
        logic [VB-1:0] value;
        logic [OB-1:0] end_offset;
        logic          converted;
        logic          overflow;
    } t_parse_result;

    // One directed string: radix to run it under, body (first char carries the
    // start), closing char, and a hand-written result where it is obvious.
    typedef struct {
        logic [RADIX_W-1:0] radix;
        string              body;
        logic [7:0]         term;
        bit                 typed;
        t_parse_result      want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_wen;
    logic [RADIX_W-1:0]   cfg_wdata;

    stip_char_if   chn_if();
    stip_result_if res_if();

    string_to_integer_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (chn_if),
        .o_out       (res_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: shadow of the radix register plus the parse state
    // ---------------------------------------------------------------
    logic [RADIX_W-1:0] radix_reg  = RADIX_RESET;
    t_parse_phase       prs_phase  = PS_IDLE;
    logic               prs_neg    = 1'b0;
    logic [RADIX_W-1:0] prs_base   = '0;      // base latched for the current string
    logic [63:0]        prs_acc    = '0;      // magnitude so far
    t_digit_state       prs_digits = DG_NONE;
    logic [OB-1:0]      prs_pos    = '0;

    t_parse_result parse_results_due[$];
    int            fail_count  = 0;
    int            results_seen = 0;
    int            chars_sent  = 0;
    bit            quiet       = 1'b0;       // no gaps on either side while set

    // Directed strings. Extremes in base 36 keep them short: "zik0zj" is the
    // signed max, seven z's overflow.
    t_row plan [6] = '{
        '{6'd36, "zik0zj",   8'h00, 1'b1, '{32'h7fff_ffff, 16'd6, 1'b1, 1'b0}},
        '{6'd36, "-zzzzzzz", 8'h21, 1'b1, '{32'h8000_0000, 16'd8, 1'b1, 1'b1}},
        // radix out of range: the very first char closes the string empty
        '{6'd63, "5",        8'h00, 1'b1, '0},
        // auto radix, "0x" with no hex digit: the 0 alone is the number
        '{6'd0,  " 0x",      8'h67, 1'b1, '{32'h0, 16'd2, 1'b1, 1'b0}},
        '{6'd0,  "017",      8'h00, 1'b0, '0},
        // whitespace and a sign, no digits
        '{6'd10, "\t-",      8'h00, 1'b1, '0}
    };

    function automatic int char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
        return NO_DIGIT;
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'((($urandom_range(1) == 1) ? CH_LA : CH_UA) + v - 10);
    endfunction

    // multiply-add with the strtol cutoff test; once saturated, stays saturated
    function automatic void add_digit(input int d);
        logic [63:0] lim;
        logic [63:0] cutoff;
        logic [63:0] cutlim;
        lim    = prs_neg ? VMAX + 64'd1 : VMAX;
        cutoff = lim / prs_base;
        cutlim = lim % prs_base;
        if (prs_digits == DG_OVF || prs_acc > cutoff ||
            (prs_acc == cutoff && 64'(d) > cutlim)) begin
            prs_digits = DG_OVF;
        end else begin
            prs_acc    = prs_acc * prs_base + 64'(d);
            prs_digits = DG_SOME;
        end
    endfunction

    function automatic t_parse_result close_string(input logic [OB-1:0] at);
        t_parse_result r;
        logic [63:0]   v;
        r = '0;
        if (prs_digits != DG_NONE) begin
            if (prs_digits == DG_OVF) v = prs_neg ? VMAX + 64'd1 : VMAX;
            else                      v = prs_neg ? 64'd0 - prs_acc : prs_acc;
            r.value      = v[VB-1:0];
            r.end_offset = at;
            r.converted  = 1'b1;
            r.overflow   = (prs_digits == DG_OVF);
        end
        prs_phase = PS_IDLE;
        return r;
    endfunction

    function automatic bit digit_or_close(input logic [7:0] c, input logic [OB-1:0] at,
                                          output t_parse_result r);
        int d;
        d = char_digit(c);
        r = '0;
        if (d < prs_base) begin
            add_digit(d);
            return 1'b0;
        end
        r = close_string(at);
        return 1'b1;
    endfunction

    // Advances the parse by one char word; returns 1 when it closes a string.
    function automatic bit parse_char(input logic [7:0] c, input logic s,
                                      output t_parse_result r);
        logic [OB-1:0] at;
        int            d;
        r = '0;
        if (s) begin
            prs_phase  = PS_SPACE;
            prs_neg    = 1'b0;
            prs_base   = '0;
            prs_acc    = '0;
            prs_digits = DG_NONE;
            prs_pos    = '0;
        end
        at = prs_pos;
        if (prs_pos != '1) prs_pos++;
        case (prs_phase)
            PS_SPACE, PS_SIGNED: begin
                if (prs_phase == PS_SPACE) begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return 1'b0;
                    if (c == CH_MINUS) begin
                        prs_neg   = 1'b1;
                        prs_phase = PS_SIGNED;
                        return 1'b0;
                    end
                    if (c == CH_PLUS) begin
                        prs_phase = PS_SIGNED;
                        return 1'b0;
                    end
                end
                // first char of the number itself: base gets latched here
                if (c == CH_ZERO && (radix_reg == RADIX_AUTO || radix_reg == RADIX_HEX)) begin
                    prs_base = (radix_reg == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                    add_digit(0);
                    prs_phase = PS_ZERO;
                    return 1'b0;
                end
                if (radix_reg == RADIX_AUTO) prs_base = RADIX_DEC;
                else if (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX) prs_base = radix_reg;
                else prs_base = '0;
                prs_phase = PS_DIGITS;
                return digit_or_close(c, at, r);
            end
            PS_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    prs_base  = RADIX_HEX;
                    prs_phase = PS_PREFIX;
                    return 1'b0;
                end
                prs_phase = PS_DIGITS;
                return digit_or_close(c, at, r);
            end
            PS_PREFIX: begin
                d = char_digit(c);
                if (d < RADIX_HEX) begin
                    add_digit(d);
                    prs_phase = PS_DIGITS;
                    return 1'b0;
                end
                // no hex digit after "0x": end points back at the x
                r = close_string((at > 0) ? at - 1'b1 : '0);
                return 1'b1;
            end
            PS_DIGITS: return digit_or_close(c, at, r);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void report_fail(input string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("%s", what);
    endfunction

    // ---------------------------------------------------------------
    // Char side. valid stays up across back-to-back words and only drops
    // on a gap, so it never gets two NBAs in one step.
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic s,
                             input bit typed = 1'b0, input t_parse_result want = '0);
        t_parse_result got;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            chn_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        chn_if.valid     <= 1'b1;
        chn_if.ch        <= c;
        chn_if.start_req <= s;
        do @(posedge i_clk); while (!chn_if.ready);
        chars_sent++;
        if (parse_char(c, s, got)) parse_results_due.push_back(typed ? want : got);
    endtask

    // Drop valid, let every owed result come out, then give the pipe time to
    // finish any word that produced nothing.
    task automatic settle();
        chn_if.valid <= 1'b0;
        while (parse_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] rdx);
        cfg_wen   <= 1'b1;
        cfg_wdata <= rdx;
        @(posedge i_clk);
        cfg_wen   <= 1'b0;
        radix_reg  = rdx;
    endtask

    // Mostly well-formed strings (space, sign, prefix, digits legal for the
    // base, random closer, trailing junk), the rest random bytes with stray
    // restarts.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         base;
        int         n;
        bit         noise;
        bit         st;
        text  = {};
        noise = ($urandom_range(9) >= 8);
        if (!noise) begin
            repeat ($urandom_range(2)) begin
                n = $urandom_range(5);
                text.push_back((n == 5) ? CH_SPACE : 8'(CH_TAB + n));
            end
            case ($urandom_range(2))
                1:       text.push_back(CH_PLUS);
                2:       text.push_back(CH_MINUS);
                default: ;
            endcase
            base = (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX) ? int'(radix_reg) : 10;
            if ((radix_reg == RADIX_AUTO || radix_reg == RADIX_HEX) &&
                $urandom_range(1) == 1) begin
                text.push_back(CH_ZERO);
                base = (radix_reg == RADIX_AUTO) ? 8 : 16;
                if ($urandom_range(3) != 0) begin
                    text.push_back(($urandom_range(1) == 1) ? CH_LX : CH_UX);
                    base = 16;
                end
            end
            // a quarter of the strings get 20 to 40 digits, the rest up to 10
            n = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
            repeat (n) text.push_back(digit_char($urandom_range(base - 1)));
            text.push_back(8'($urandom));
            repeat ($urandom_range(2)) text.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
        end
        foreach (text[i]) begin
            if (noise) st = (i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(7) == 0);
            else       st = (i == 0);
            send_char(text[i], st);
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        logic [7:0]         c;
        logic [RADIX_W-1:0] rdx;
        logic [RADIX_W-1:0] radix_plan [8];
        int                 budget;

        radix_plan = '{RADIX_DEC, RADIX_HEX, RADIX_AUTO, RADIX_MIN, RADIX_MAX, RADIX_OCT,
                       6'd1, 6'd63};
        i_rst_n          <= 1'b0;
        cfg_wen          <= 1'b0;
        cfg_wdata        <= RADIX_RESET;
        chn_if.valid     <= 1'b0;
        chn_if.ch        <= CH_NUL;
        chn_if.start_req <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before any start the parser is idle and must swallow this
        send_char(8'hFF, 1'b0);

        foreach (plan[k]) begin
            if (plan[k].radix != radix_reg) begin
                settle();
                set_radix(plan[k].radix);
            end
            for (int i = 0; i <= plan[k].body.len(); i++) begin
                c = (i < plan[k].body.len()) ? 8'(plan[k].body[i]) : plan[k].term;
                send_char(c, i == 0, plan[k].typed, plan[k].want);
            end
        end

        // random phases, one radix each; third phase runs without gaps
        for (int k = 0; k < RAND_PHASES; k++) begin
            settle();
            rdx = (k < 8) ? radix_plan[k] : 6'($urandom_range(63));
            set_radix(rdx);
            quiet  = (k == 2);
            budget = chars_sent + ((k == 0) ? FIRST_BUDGET : PHASE_BUDGET);
            while (chars_sent < budget) send_random_string();
            // a NUL closes whatever string is still open before the radix moves
            send_char(CH_NUL, 1'b0);
        end
        settle();

        if (fail_count == 0) begin
            $display("string_to_integer_parser verification clean");
        end else begin
            $display("string_to_integer_parser verification failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off, timed here,
    // that lets the queue fill and stall the char input.
    // ---------------------------------------------------------------
    initial begin
        int            hold_left;
        bit            held;
        t_parse_result want;
        t_parse_result got;
        hold_left = 0;
        held      = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                results_seen++;
                got = '{res_if.value, res_if.end_offset, res_if.converted, res_if.overflow};
                if (parse_results_due.size() == 0) begin
                    report_fail($sformatf({"%0t: result word with none due: ",
                                           "value %h end %0d conv %0b ovf %0b"},
                                          $realtime, got.value, got.end_offset, got.converted,
                                          got.overflow));
                end else begin
                    want = parse_results_due.pop_front();
                    if (got.value !== want.value || got.end_offset !== want.end_offset ||
                        got.converted !== want.converted || got.overflow !== want.overflow) begin
                        report_fail($sformatf({"%0t: result %0d mismatch: expected value %h end %0d ",
                                               "conv %0b ovf %0b, got value %h end %0d conv %0b ovf %0b"},
                                              $realtime, results_seen, want.value, want.end_offset,
                                              want.converted, want.overflow, got.value,
                                              got.end_offset, got.converted, got.overflow));
                    end
                end
                if (!held && results_seen == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("string_to_integer_parser verification failed");
        $finish;
    end

endmodule
